@@ hdl/dlc_pkg.sv @@
`timescale 1ns / 1ps

package dlc_pkg;

    // crc-16, reflected, as used on the link layer
    localparam logic [15:0] CRC_POLY   = 16'hA6BC;
    localparam logic [15:0] CRC_INIT   = 16'h0000;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

    // header is 8 bytes plus crc, a full data block is 16 bytes plus crc
    localparam int HEAD_TOTAL  = 10;
    localparam int BLOCK_TOTAL = 18;

    localparam int HPOS_W = 4;
    localparam int BPOS_W = 5;

    localparam logic [HPOS_W-1:0] HEAD_DONE  = HPOS_W'(HEAD_TOTAL);
    localparam logic [BPOS_W-1:0] BLOCK_DONE = BPOS_W'(BLOCK_TOTAL);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_HEAD_BAD  = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_BLOCK_BAD = 3'd4
    } status_t;

    // result of one byte step, handed from the tracker to the output stage
    typedef struct packed {
        logic    done;
        status_t status;
    } track_result_t;

    // one byte through the reflected crc
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // inverted crc, low byte first, against the two held bytes
    function automatic logic crc_matches(input logic [15:0] crc, input logic [15:0] held);
        logic [15:0] fin;
        fin = crc ^ CRC_XOROUT;
        return (fin[7:0] == held[15:8]) && (fin[15:8] == held[7:0]);
    endfunction

endpackage

@@ hdl/dnp3_link_frame_crc_checker.sv @@
`timescale 1ns / 1ps
// m_axis_tvalid rises once the final frame byte has passed the input register
//   and then the output register; that byte waits while the output is still full
// throughput: one byte per cycle outside that wait; the single-byte crc step sits
//   between the input register and tracker state; the status lands in the output register
// reset: aresetn low clears the tracker, the input register and the output valid,
//   so the next byte starts a new frame

module dnp3_link_frame_crc_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] frame_byte
    input  logic       s_axis_tlast,   // end_of_frame
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] check_status, [7:3] zero
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic                   out_valid_reg;
    dlc_pkg::status_t       out_status_reg;
    logic                   out_free;
    logic                   advance;
    dlc_pkg::track_result_t result;

    // a byte moves on unless its status would find the output still full
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    dlc_frame_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .result  (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (result.done) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.done) begin
            out_status_reg <= result.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_status_reg};

endmodule

@@ hdl/dlc_frame_track.sv @@
`timescale 1ns / 1ps

module dlc_frame_track (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             byte_in,
    input  logic                   last_in,
    output dlc_pkg::track_result_t result
);

    logic [15:0]                 crc_reg, crc_next;
    logic [15:0]                 held_reg, held_next;
    logic [dlc_pkg::HPOS_W-1:0]  hpos_reg, hpos_next;
    logic [dlc_pkg::BPOS_W-1:0]  bpos_reg, bpos_next;
    logic                        hfail_reg, hfail_next;
    logic                        bfail_reg, bfail_next;

    logic                        in_header;
    logic                        feed_crc;
    logic [15:0]                 crc_upd;
    logic [15:0]                 held_upd;
    dlc_pkg::status_t            status;

    // advance the lagged crc and the two-byte hold
    always_comb begin
        in_header = (hpos_reg < dlc_pkg::HEAD_DONE);
        feed_crc  = in_header ? (hpos_reg >= dlc_pkg::HPOS_W'(2))
                              : (bpos_reg >= dlc_pkg::BPOS_W'(2));
        crc_upd   = feed_crc ? dlc_pkg::crc_byte(crc_reg, held_reg[15:8]) : crc_reg;
        held_upd  = {held_reg[7:0], byte_in};
    end

    // section bookkeeping and the checks at block boundaries
    always_comb begin
        crc_next   = crc_upd;
        held_next  = held_upd;
        hpos_next  = hpos_reg;
        bpos_next  = bpos_reg;
        hfail_next = hfail_reg;
        bfail_next = bfail_reg;
        if (in_header) begin
            hpos_next = hpos_reg + dlc_pkg::HPOS_W'(1);
            if (hpos_next == dlc_pkg::HEAD_DONE) begin
                if (!dlc_pkg::crc_matches(crc_upd, held_upd)) begin
                    hfail_next = 1'b1;
                end
                crc_next  = dlc_pkg::CRC_INIT;
                held_next = '0;
                bpos_next = '0;
            end
        end else begin
            bpos_next = bpos_reg + dlc_pkg::BPOS_W'(1);
            if (bpos_next >= dlc_pkg::BLOCK_DONE) begin
                if (!dlc_pkg::crc_matches(crc_upd, held_upd)) begin
                    bfail_next = 1'b1;
                end
                crc_next  = dlc_pkg::CRC_INIT;
                held_next = '0;
                bpos_next = '0;
            end
        end
    end

    // frame status on the final byte, by precedence
    always_comb begin
        if (hpos_next < dlc_pkg::HEAD_DONE) begin
            status = dlc_pkg::ST_SHORT;
        end else if (hfail_next) begin
            status = dlc_pkg::ST_HEAD_BAD;
        end else if (bpos_next == dlc_pkg::BPOS_W'(1) || bpos_next == dlc_pkg::BPOS_W'(2)) begin
            status = dlc_pkg::ST_TRUNC;
        end else if (bfail_next) begin
            status = dlc_pkg::ST_BLOCK_BAD;
        end else if (bpos_next >= dlc_pkg::BPOS_W'(3)
                     && !dlc_pkg::crc_matches(crc_next, held_next)) begin
            status = dlc_pkg::ST_BLOCK_BAD;
        end else begin
            status = dlc_pkg::ST_OK;
        end
        result.done   = step && last_in;
        result.status = status;
    end

    // state registers, cleared after each frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= dlc_pkg::CRC_INIT;
            held_reg  <= '0;
            hpos_reg  <= '0;
            bpos_reg  <= '0;
            hfail_reg <= 1'b0;
            bfail_reg <= 1'b0;
        end else if (step) begin
            if (last_in) begin
                crc_reg   <= dlc_pkg::CRC_INIT;
                held_reg  <= '0;
                hpos_reg  <= '0;
                bpos_reg  <= '0;
                hfail_reg <= 1'b0;
                bfail_reg <= 1'b0;
            end else begin
                crc_reg   <= crc_next;
                held_reg  <= held_next;
                hpos_reg  <= hpos_next;
                bpos_reg  <= bpos_next;
                hfail_reg <= hfail_next;
                bfail_reg <= bfail_next;
            end
        end
    end

    // header counter never passes the end of the header
    assert property (@(posedge aclk) disable iff (!aresetn)
        hpos_reg <= dlc_pkg::HEAD_DONE)
        else $error("header position out of range");

    // block counter wraps before a full block plus crc
    assert property (@(posedge aclk) disable iff (!aresetn)
        bpos_reg < dlc_pkg::BLOCK_DONE)
        else $error("block position out of range");

    // data block bytes only after the header is complete
    assert property (@(posedge aclk) disable iff (!aresetn)
        (bpos_reg != '0) |-> (hpos_reg == dlc_pkg::HEAD_DONE))
        else $error("block bytes counted inside the header");

    // the final byte leaves the tracker at the start of a new frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && last_in) |=> (hpos_reg == '0 && !hfail_reg && !bfail_reg))
        else $error("state not cleared after frame end");

endmodule

@@ bench/dnp3_link_frame_crc_checker_test.sv @@
`timescale 1ns / 1ps

module dnp3_link_frame_crc_checker_test;

    // predicts one status per frame and matches it against the status stream
    class frame_status_scoreboard;
        logic [15:0]      trail_crc;
        logic [15:0]      last_two;
        int unsigned      head_cnt;
        int unsigned      blk_cnt;
        bit               head_bad;
        bit               blk_bad;
        dlc_pkg::status_t status_q[$];
        int               errors;

        function new();
            errors = 0;
            new_frame();
        endfunction

        // bit-serial form of the reflected crc, one byte
        static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc;
            for (int i = 0; i < 8; i++) begin
                if (c[0] ^ b[i]) begin
                    c = {1'b0, c[15:1]} ^ dlc_pkg::CRC_POLY;
                end else begin
                    c = {1'b0, c[15:1]};
                end
            end
            return c;
        endfunction

        // crc goes out inverted, low byte first, so the older held byte is the low one
        static function bit crc_good(logic [15:0] crc, logic [15:0] held);
            logic [15:0] fin;
            fin = crc ^ dlc_pkg::CRC_XOROUT;
            return fin == {held[7:0], held[15:8]};
        endfunction

        function void new_section();
            trail_crc = dlc_pkg::CRC_INIT;
            last_two  = '0;
            blk_cnt   = 0;
        endfunction

        function void new_frame();
            new_section();
            head_cnt = 0;
            head_bad = 1'b0;
            blk_bad  = 1'b0;
        endfunction

        // crc runs two bytes behind the held pair
        function void push_byte(int unsigned count_before, logic [7:0] b);
            if (count_before >= 2) begin
                trail_crc = crc_update(trail_crc, last_two[15:8]);
            end
            last_two = {last_two[7:0], b};
        endfunction

        function void note_byte(logic [7:0] b, bit last);
            dlc_pkg::status_t st;
            if (head_cnt < dlc_pkg::HEAD_TOTAL) begin
                push_byte(head_cnt, b);
                head_cnt++;
                if (head_cnt == dlc_pkg::HEAD_TOTAL) begin
                    if (!crc_good(trail_crc, last_two)) head_bad = 1'b1;
                    new_section();
                end
            end else begin
                push_byte(blk_cnt, b);
                blk_cnt++;
                if (blk_cnt >= dlc_pkg::BLOCK_TOTAL) begin
                    if (!crc_good(trail_crc, last_two)) blk_bad = 1'b1;
                    new_section();
                end
            end
            if (!last) return;

            // precedence: short, header, truncated, block
            if (head_cnt < dlc_pkg::HEAD_TOTAL) begin
                st = dlc_pkg::ST_SHORT;
            end else if (head_bad) begin
                st = dlc_pkg::ST_HEAD_BAD;
            end else if (blk_cnt == 1 || blk_cnt == 2) begin
                st = dlc_pkg::ST_TRUNC;
            end else if (blk_bad) begin
                st = dlc_pkg::ST_BLOCK_BAD;
            end else if (blk_cnt >= 3 && !crc_good(trail_crc, last_two)) begin
                st = dlc_pkg::ST_BLOCK_BAD;
            end else begin
                st = dlc_pkg::ST_OK;
            end
            status_q.push_back(st);
            new_frame();
        endfunction

        function void check_result(logic [7:0] data);
            dlc_pkg::status_t want;
            if (status_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("status transfer with none pending: got %0d", data);
                return;
            end
            want = status_q.pop_front();
            if (data !== {5'b00000, want}) begin
                errors++;
                if (errors <= 10) begin
                    $display("status mismatch: expected %s (%0d), got %0d (tdata %02h)",
                             want.name(), want, data[2:0], data);
                end
            end
        endfunction
    endclass

    localparam int HEAD_DATA  = dlc_pkg::HEAD_TOTAL - 2;
    localparam int BLOCK_DATA = dlc_pkg::BLOCK_TOTAL - 2;

    // byte fill patterns
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    frame_status_scoreboard status_board = new();

    logic [7:0] frame_q[$];
    int         burst_left = 0;
    int         bytes_sent = 0;
    logic [8:0] ready_cycle = '0;
    int         stall_left = 0;

    dnp3_link_frame_crc_checker u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // safety limit
    initial begin
        #2_000_000;
        $display("dnp3_link_frame_crc_checker_test failed");
        $finish;
    end

    // receiver stalls: random short stalls, with an open stretch every other window
    always @(posedge aclk) begin
        ready_cycle <= ready_cycle + 1'b1;
        if (ready_cycle[8]) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // input transfers feed the predictor
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            status_board.note_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    // status transfers get checked
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            status_board.check_result(m_axis_tdata);
        end
    end

    function automatic logic [7:0] fill_byte(int fill);
        case (fill)
            FILL_ZERO: begin
                return 8'h00;
            end
            FILL_ONES: begin
                return 8'hFF;
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // crc over frame_q from a given index, optionally damaged
    function automatic void append_crc(int from, bit corrupt);
        logic [15:0] c;
        c = dlc_pkg::CRC_INIT;
        for (int i = from; i < frame_q.size(); i++) begin
            c = frame_status_scoreboard::crc_update(c, frame_q[i]);
        end
        c = c ^ dlc_pkg::CRC_XOROUT;
        if (corrupt) c = c ^ 16'($urandom_range(1, 65535));
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endfunction

    function automatic void make_frame(bit head_bad, int full_blocks, int bad_block,
                                       int tail_data, bit tail_bad, int trunc_len, int fill);
        int start;
        frame_q.delete();
        repeat (HEAD_DATA) frame_q.push_back(fill_byte(fill));
        append_crc(0, head_bad);
        for (int b = 0; b < full_blocks; b++) begin
            start = frame_q.size();
            repeat (BLOCK_DATA) frame_q.push_back(fill_byte(fill));
            append_crc(start, b == bad_block);
        end
        if (tail_data > 0) begin
            start = frame_q.size();
            repeat (tail_data) frame_q.push_back(fill_byte(fill));
            append_crc(start, tail_bad);
        end
        repeat (trunc_len) frame_q.push_back(fill_byte(fill));
    endfunction

    function automatic void make_raw(int len, int fill);
        frame_q.delete();
        repeat (len) frame_q.push_back(fill_byte(fill));
    endfunction

    // push frame_q through the input channel in bursts with random gaps
    task automatic send_frame();
        int gap;
        for (int i = 0; i < frame_q.size(); i++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 32);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= frame_q[i];
            s_axis_tlast  <= (i == frame_q.size() - 1);
            @(posedge aclk);
            while (!s_axis_tready) @(posedge aclk);
            burst_left--;
            bytes_sent++;
        end
    endtask

    initial begin
        int pick;
        int nb;
        int bad_blk;
        int tail;
        int trunc;
        int fill;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: short frames
        make_raw(1, FILL_ZERO);                          send_frame();
        make_raw(dlc_pkg::HEAD_TOTAL - 1, FILL_ONES);    send_frame();
        // header only, good and bad
        make_frame(0, 0, -1, 0, 0, 0, FILL_ONES);        send_frame();
        make_frame(1, 0, -1, 0, 0, 0, FILL_ZERO);        send_frame();
        // bad header outranks a truncated remainder
        make_frame(1, 0, -1, 0, 0, 1, FILL_RANDOM);      send_frame();
        // truncated remainders of one and two bytes
        make_frame(0, 0, -1, 0, 0, 1, FILL_RANDOM);      send_frame();
        make_frame(0, 0, -1, 0, 0, 2, FILL_ONES);        send_frame();
        // one data byte tail, and a sixteen byte tail that counts as a full block
        make_frame(0, 0, -1, 1, 0, 0, FILL_ZERO);        send_frame();
        make_frame(0, 0, -1, BLOCK_DATA, 0, 0, FILL_ONES); send_frame();
        // truncation outranks a bad full block
        make_frame(0, 1, 0, 0, 0, 2, FILL_RANDOM);       send_frame();
        // bad full block with good tail, good full block with bad tail
        make_frame(0, 1, 0, 5, 0, 0, FILL_RANDOM);       send_frame();
        make_frame(0, 1, -1, 5, 1, 0, FILL_ZERO);        send_frame();
        make_frame(0, 2, -1, 15, 0, 0, FILL_RANDOM);     send_frame();

        // random frames, mostly well formed
        while (bytes_sent < 700) begin
            pick = $urandom_range(0, 9);
            fill = ($urandom_range(0, 15) == 0) ? $urandom_range(FILL_ZERO, FILL_ONES)
                                                : FILL_RANDOM;
            if (pick < 7) begin
                nb = $urandom_range(0, 2);
                bad_blk = ($urandom_range(0, 5) == 0) ? $urandom_range(0, nb) : -1;
                tail = 0;
                trunc = 0;
                case ($urandom_range(0, 9))
                    0: begin
                        trunc = $urandom_range(1, 2);
                    end
                    1, 2: begin
                        tail = 0;
                    end
                    default: begin
                        tail = $urandom_range(1, BLOCK_DATA);
                    end
                endcase
                make_frame($urandom_range(0, 7) == 0, nb, bad_blk, tail,
                           $urandom_range(0, 7) == 0, trunc, fill);
            end else if (pick == 7) begin
                make_raw($urandom_range(1, dlc_pkg::HEAD_TOTAL - 1), fill);
            end else begin
                make_raw($urandom_range(dlc_pkg::HEAD_TOTAL, 40), fill);
            end
            send_frame();
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding statuses, then allow for pipeline latency
        while (status_board.status_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (status_board.errors == 0 && status_board.status_q.size() == 0) begin
            $display("dnp3_link_frame_crc_checker_test passed");
        end else begin
            $display("dnp3_link_frame_crc_checker_test failed");
        end
        $finish;
    end

endmodule
